FILE: design/dur_iso_pkg.sv
// Shared types, constants and helper functions for the ISO 8601 duration formatter.
package dur_iso_pkg;

	localparam int FIELD_BITS_DEF = 16;
	localparam int NUM_PARTS      = 6;
	localparam int FIRST_TIME     = 3;
	localparam int PART_W         = 3;

	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_T    = 8'h54;
	localparam logic [7:0] CH_Y    = 8'h59;
	localparam logic [7:0] CH_M    = 8'h4D;
	localparam logic [7:0] CH_D    = 8'h44;
	localparam logic [7:0] CH_H    = 8'h48;
	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_ZERO = 8'h30;

	localparam logic [PART_W-1:0] PART_YEARS   = 3'd0;
	localparam logic [PART_W-1:0] PART_MONTHS  = 3'd1;
	localparam logic [PART_W-1:0] PART_DAYS    = 3'd2;
	localparam logic [PART_W-1:0] PART_HOURS   = 3'd3;
	localparam logic [PART_W-1:0] PART_MINUTES = 3'd4;
	localparam logic [PART_W-1:0] PART_SECONDS = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUT_P,
		ST_NEXT,
		ST_PUT_T,
		ST_CONV,
		ST_SCAN,
		ST_PUT_D,
		ST_PUT_L
	} state_t;

	// decimal digits needed for the largest value of a field this wide
	function automatic int dec_digits(input int bits);
		longint unsigned v;
		int n;
		v = (64'd1 << bits) - 64'd1;
		n = 0;
		for (int i = 0; i < 20; i++) begin
			if (v != 0) begin
				v = v / 10;
				n = n + 1;
			end
		end
		return n;
	endfunction

	function automatic logic [7:0] part_letter(input logic [PART_W-1:0] p);
		logic [7:0] ch;
		unique case (p)
			PART_YEARS:   ch = CH_Y;
			PART_MONTHS:  ch = CH_M;
			PART_DAYS:    ch = CH_D;
			PART_HOURS:   ch = CH_H;
			PART_MINUTES: ch = CH_M;
			default:      ch = CH_S;
		endcase
		return ch;
	endfunction

endpackage

FILE: design/dur_iso_bcd.sv
// Shared binary to BCD converter: shift-and-add-3, one input bit per cycle.
module dur_iso_bcd #(
	parameter int FIELD_BITS = dur_iso_pkg::FIELD_BITS_DEF,
	localparam int NDIG      = dur_iso_pkg::dec_digits(FIELD_BITS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [FIELD_BITS-1:0]       value,
	output logic [NDIG-1:0][3:0]        digits,
	output logic                        done
);
	import dur_iso_pkg::*;

	localparam int CNT_W = $clog2(FIELD_BITS);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [FIELD_BITS-1:0] bin_q;
	logic [NDIG-1:0][3:0]  bcd_q;
	logic [NDIG-1:0][3:0]  adj;
	logic [NDIG*4-1:0]     adj_flat;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	assign adj_flat = adj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(FIELD_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[FIELD_BITS-2:0], 1'b0};
			bcd_q <= {adj_flat[NDIG*4-2:0], bin_q[FIELD_BITS-1]};
		end
	end

	assign digits = bcd_q;
	assign done   = done_q;

endmodule

FILE: design/duration_to_iso8601_text_top.sv
// Top level of the ISO 8601 duration formatter: sequencer, field store and output register.
//
// channel  dir  tdata (low bit up)                               tlast
// s_axis   in   years, months, days, hours, minutes, seconds     -
// m_axis   out  text_char                                        last_char
//
// Each nonzero part goes through the serial BCD converter, one bit a cycle, and then its
// digits and designator letter go out; zero parts are skipped, and the time designator
// is sent once ahead of the first nonzero time part. Characters leave at most one per
// cycle through a single output register.
// s_axis_tready is high only between durations; the next one can be taken while the final
// character still waits. A stall on m_axis holds the sequencer. Reset clears control only.
module duration_to_iso8601_text_top #(
	parameter int FIELD_BITS = dur_iso_pkg::FIELD_BITS_DEF,
	localparam int S_TDATA_W = ((dur_iso_pkg::NUM_PARTS * FIELD_BITS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// years, months, days, hours, minutes, seconds; zero fill at the top
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// text_char
	output logic [7:0]           m_axis_tdata,
	output logic                 m_axis_tlast
);
	import dur_iso_pkg::*;

	localparam int NDIG  = dec_digits(FIELD_BITS);
	localparam int DIG_W = $clog2(NDIG);

	state_t state_q, state_d;

	logic [NUM_PARTS-1:0][FIELD_BITS-1:0] in_fields;
	logic [FIELD_BITS-1:0]                vals_q [NUM_PARTS];
	logic [NUM_PARTS-1:0]                 nz_q;
	logic [PART_W-1:0]                    part_q;
	logic                                 t_sent_q;
	logic [DIG_W-1:0]                     dig_q;
	logic [DIG_W-1:0]                     top_idx;
	logic [NDIG-1:0][3:0]                 digits;
	logic                                 bcd_done;
	logic                                 bcd_start;

	logic       s_acc;
	logic       out_free;
	logic       emit;
	logic [7:0] emit_char;
	logic       emit_last;
	logic       last_letter;
	logic       part_nz;
	logic       need_t;

	logic       m_valid_q;
	logic [7:0] m_data_q;
	logic       m_last_q;

	always_comb begin
		for (int i = 0; i < NUM_PARTS; i++) begin
			in_fields[i] = s_axis_tdata[i*FIELD_BITS +: FIELD_BITS];
		end
	end

	assign s_acc       = s_axis_tvalid && s_axis_tready;
	assign out_free    = !m_valid_q || m_axis_tready;
	assign part_nz     = nz_q[part_q];
	assign need_t      = (part_q >= PART_W'(FIRST_TIME)) && !t_sent_q;
	assign last_letter = ((nz_q >> (part_q + 3'd1)) == '0);

	// most significant nonzero digit
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (digits[i] != 4'd0) top_idx = DIG_W'(i);
		end
	end

	dur_iso_bcd #(.FIELD_BITS(FIELD_BITS)) u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.value  (vals_q[part_q]),
		.digits (digits),
		.done   (bcd_done)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_acc) state_d = ST_PUT_P;
			ST_PUT_P: if (out_free) state_d = (nz_q == '0) ? ST_IDLE : ST_NEXT;
			ST_NEXT: begin
				if (part_q >= PART_W'(NUM_PARTS)) state_d = ST_IDLE;
				else if (!part_nz)                state_d = ST_NEXT;
				else if (need_t)                  state_d = ST_PUT_T;
				else                              state_d = ST_CONV;
			end
			ST_PUT_T: if (out_free) state_d = ST_NEXT;
			ST_CONV:  if (bcd_done) state_d = ST_SCAN;
			ST_SCAN:  state_d = ST_PUT_D;
			ST_PUT_D: if (out_free && dig_q == '0) state_d = ST_PUT_L;
			ST_PUT_L: if (out_free) state_d = last_letter ? ST_IDLE : ST_NEXT;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		bcd_start     = 1'b0;
		emit          = 1'b0;
		emit_char     = CH_P;
		emit_last     = 1'b0;
		unique case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_PUT_P: begin
				emit      = out_free;
				emit_char = CH_P;
				emit_last = (nz_q == '0);
			end
			ST_NEXT: bcd_start = (part_q < PART_W'(NUM_PARTS)) && part_nz && !need_t;
			ST_PUT_T: begin
				emit      = out_free;
				emit_char = CH_T;
			end
			ST_PUT_D: begin
				emit      = out_free;
				emit_char = CH_ZERO + {4'd0, digits[dig_q]};
			end
			ST_PUT_L: begin
				emit      = out_free;
				emit_char = part_letter(part_q);
				emit_last = last_letter;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_q     <= '0;
			part_q   <= '0;
			t_sent_q <= 1'b0;
			dig_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						for (int i = 0; i < NUM_PARTS; i++) nz_q[i] <= |in_fields[i];
						part_q   <= '0;
						t_sent_q <= 1'b0;
					end
				end
				ST_NEXT: begin
					if (part_q < PART_W'(NUM_PARTS) && !part_nz)
						part_q <= part_q + PART_W'(1);
				end
				ST_PUT_T: if (out_free) t_sent_q <= 1'b1;
				ST_SCAN:  dig_q <= top_idx;
				ST_PUT_D: if (out_free && dig_q != '0) dig_q <= dig_q - DIG_W'(1);
				ST_PUT_L: if (out_free) part_q <= part_q + PART_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			for (int i = 0; i < NUM_PARTS; i++) vals_q[i] <= in_fields[i];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_data_q <= emit_char;
			m_last_q <= emit_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule

FILE: design/dur_iso_chk.sv
// Port-level checker for the duration formatter, bound to the top level.
module dur_iso_chk #(
	parameter int FIELD_BITS = dur_iso_pkg::FIELD_BITS_DEF,
	localparam int S_TDATA_W = ((dur_iso_pkg::NUM_PARTS * FIELD_BITS + 7) / 8) * 8
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic [S_TDATA_W-1:0] s_axis_tdata,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [7:0]           m_axis_tdata,
	input logic                 m_axis_tlast
);
	import dur_iso_pkg::*;

	logic first_q;

	// next output transaction opens a new text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (m_axis_tvalid && m_axis_tready) begin
			first_q <= m_axis_tlast;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after an input transaction");

	a_text_starts_p: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && first_q |-> m_axis_tdata == CH_P)
		else $error("text does not start with P");

	a_no_ready_mid_text: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input ready while a text is still being produced");

	a_last_is_letter: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata == CH_P || m_axis_tdata == CH_Y
			|| m_axis_tdata == CH_M || m_axis_tdata == CH_D || m_axis_tdata == CH_H
			|| m_axis_tdata == CH_S))
		else $error("final character is not a designator");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("stalled output transaction changed");

endmodule

bind duration_to_iso8601_text_top dur_iso_chk #(.FIELD_BITS(FIELD_BITS)) u_dur_iso_chk (.*);
